// ===== rtl/rpt_pkg.sv =====
// ----------------------------------------------------------------------------
// rpt_pkg
// Shared types for the ranked-pairs tally: input word, result word, states.
// ----------------------------------------------------------------------------
package rpt_pkg;

    // largest number of candidates the tally is built for
    localparam int MAX_CANDIDATES = 8;

    typedef struct packed {
        logic       mode;
        logic [3:0] candidate;
    } t_in_word;

    typedef struct packed {
        logic       kind;
        logic [3:0] who;
        logic       last;
    } t_out_word;

    localparam logic MODE_RANK  = 1'b0;
    localparam logic MODE_CLOSE = 1'b1;
    localparam logic KIND_WIN   = 1'b0;
    localparam logic KIND_BAD   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REC_RD,
        ST_REC_WR,
        ST_CLR,
        ST_PAIR_RD,
        ST_PAIR_CMP,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_LOCK,
        ST_REACH,
        ST_EMIT
    } t_state;

endpackage

// ===== rtl/ranked_pairs_tally.sv =====
// ----------------------------------------------------------------------------
// ranked_pairs_tally
// Ranked-pairs election counter around one pairwise count memory.
// ----------------------------------------------------------------------------
// With n the candidate count in effect: a rank word is taken without leaving
// idle, except the word that completes a ballot, which then walks the n*(n-1)/2
// pairs of the ballot through the count memory, each pair a read and then a
// saturating write. A close word reads the two pairwise counts of each
// candidate pair and compares them, runs an insertion sort whose steps are two
// count reads and a compare, runs the lock check for each pair in turn,
// reports by visiting each candidate in use in turn and finally clears all
// MAX_CANDIDATES^2 entries of the count memory, one entry per cycle. A close
// after an invalid vote only runs the clear. The same clearing pass runs after
// reset, so busy is high after reset until the clear is done. The receiver
// cannot stall: each result is shown for one cycle with o_res_valid, and an
// invalid-vote result appears in the cycle its word is accepted. Busy is high
// throughout a ballot record or a close.
// ----------------------------------------------------------------------------
module ranked_pairs_tally #(
    parameter int COUNT_WIDTH    = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  rpt_pkg::t_in_word     i_word,
    input  logic                  i_cfg_we,
    input  logic [3:0]            i_cfg_data,
    output logic                  o_res_valid,
    output rpt_pkg::t_out_word    o_res
);
    import rpt_pkg::*;

    localparam int CW = $clog2(MAX_CANDIDATES);
    localparam int AW = 2 * CW;
    localparam int DEPTH = MAX_CANDIDATES * MAX_CANDIDATES;
    localparam int NPAIRS = MAX_CANDIDATES * (MAX_CANDIDATES - 1) / 2;
    localparam int PW = $clog2(NPAIRS + 1);
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    // count memory, one read and one write port
    logic [COUNT_WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]          rd_addr, wr_addr;
    logic                   wr_en;
    logic [COUNT_WIDTH-1:0] wr_data, r_rd_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // control and working registers
    t_state r_state, n_state;
    logic [3:0] r_ncfg;
    logic       r_abort;
    logic [4:0] r_pos;
    logic [CW-1:0] r_ranks [MAX_CANDIDATES];
    logic [CW-1:0] r_pw [NPAIRS];
    logic [CW-1:0] r_pl [NPAIRS];
    logic [PW-1:0] r_ptot;
    logic [MAX_CANDIDATES-1:0] r_lock [MAX_CANDIDATES];
    logic [4:0] r_i, r_j;
    logic [PW-1:0] r_k;
    logic [COUNT_WIDTH-1:0] r_a, r_m;
    logic [1:0] r_sub;
    logic [MAX_CANDIDATES-1:0] r_seen;
    logic [4:0] r_round;
    logic [AW:0] r_clr;
    logic [MAX_CANDIDATES-1:0] r_roots;

    logic [4:0] n_eff;
    assign n_eff = ({1'b0, r_ncfg} > 5'(MAX_CANDIDATES)) ? 5'(MAX_CANDIDATES)
                                                         : {1'b0, r_ncfg};

    function automatic logic [AW-1:0] addr(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return {a, b};
    endfunction

    logic accept;
    assign accept = start && !busy;
    assign busy = (r_state != ST_IDLE);

    // grown reachability set for one round
    logic [MAX_CANDIDATES-1:0] grown;
    always_comb begin
        grown = r_seen;
        for (int v = 0; v < MAX_CANDIDATES; v++) begin
            if (r_seen[v] && 5'(v) < n_eff) begin
                grown = grown | r_lock[v];
            end
        end
    end

    // candidates with no locked incoming edge
    logic [MAX_CANDIDATES-1:0] roots;
    always_comb begin
        roots = '1;
        for (int u = 0; u < MAX_CANDIDATES; u++) begin
            if (5'(u) < n_eff) roots = roots & ~r_lock[u];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_word.mode == MODE_CLOSE) begin
                        n_state = r_abort ? ST_CLR : ST_PAIR_RD;
                    end else if (!r_abort && {1'b0, i_word.candidate} < n_eff
                                 && ((r_pos >= n_eff) ? 5'd1 : r_pos + 5'd1) >= n_eff
                                 && n_eff > 5'd1) begin
                        n_state = ST_REC_RD;
                    end
                end
            end
            ST_REC_RD:  n_state = ST_REC_WR;
            ST_REC_WR: begin
                if (r_j + 5'd1 >= n_eff && r_i + 5'd2 >= n_eff) n_state = ST_IDLE;
                else n_state = ST_REC_RD;
            end
            ST_PAIR_RD: begin
                if (r_sub == 2'd1) n_state = ST_PAIR_CMP;
                if (n_eff < 5'd2) n_state = ST_LOCK;
            end
            ST_PAIR_CMP: begin
                if (r_j + 5'd1 >= n_eff && r_i + 5'd2 >= n_eff) n_state = ST_SORT_RD;
                else n_state = ST_PAIR_RD;
            end
            ST_SORT_RD: begin
                if ({1'b0, r_i} >= {1'b0, 5'(r_ptot)}) n_state = ST_LOCK;
                else if (r_sub == 2'd1) n_state = ST_SORT_CMP;
            end
            ST_SORT_CMP: n_state = ST_SORT_RD;
            ST_LOCK: begin
                if (r_k >= r_ptot) n_state = ST_EMIT;
                else n_state = ST_REACH;
            end
            ST_REACH: begin
                if (r_round + 5'd1 >= n_eff) n_state = ST_LOCK;
            end
            ST_EMIT: begin
                if (r_i + 5'd1 >= n_eff || n_eff == 5'd0) n_state = ST_CLR;
            end
            ST_CLR: begin
                if (r_clr == (AW + 1)'(DEPTH - 1)) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // memory addressing and write data
    logic [COUNT_WIDTH-1:0] inc;
    assign inc = (r_rd_data == CMAX) ? r_rd_data : r_rd_data + 1'b1;

    logic [CW-1:0] sw, sl;
    assign sw = r_pw[r_k[PW-1:0]];
    assign sl = r_pl[r_k[PW-1:0]];

    always_comb begin
        rd_addr = '0;
        wr_addr = addr(r_ranks[r_i[CW-1:0]], r_ranks[r_j[CW-1:0]]);
        wr_en   = 1'b0;
        wr_data = inc;
        unique case (r_state)
            ST_REC_RD: rd_addr = addr(r_ranks[r_i[CW-1:0]], r_ranks[r_j[CW-1:0]]);
            ST_REC_WR: wr_en = 1'b1;
            ST_PAIR_RD: rd_addr = (r_sub == 2'd0) ? addr(r_i[CW-1:0], r_j[CW-1:0])
                                                  : addr(r_j[CW-1:0], r_i[CW-1:0]);
            ST_SORT_RD: rd_addr = (r_sub == 2'd0) ? addr(sw, sl) : addr(sl, sw);
            ST_CLR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr[AW-1:0];
                wr_data = '0;
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        if (r_state == ST_IDLE && accept && i_word.mode == MODE_RANK && !r_abort
            && {1'b0, i_word.candidate} >= n_eff) begin
            o_res_valid = 1'b1;
            o_res.kind  = KIND_BAD;
            o_res.who   = i_word.candidate;
            o_res.last  = 1'b1;
        end else if (r_state == ST_EMIT && r_i < n_eff && r_roots[r_i[CW-1:0]]) begin
            o_res_valid = 1'b1;
            o_res.kind  = KIND_WIN;
            o_res.who   = 4'(r_i);
            o_res.last  = 1'b1;
            for (int v = 0; v < MAX_CANDIDATES; v++) begin
                if (5'(v) > r_i && 5'(v) < n_eff && r_roots[v]) o_res.last = 1'b0;
            end
        end
    end

    // sort compare: margin of the pair at slot r_k, compared against the key margin
    logic [COUNT_WIDTH-1:0] cur_m;
    assign cur_m = r_a - r_rd_data;

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_ncfg  <= 4'd8;
            r_abort <= 1'b0;
            r_pos   <= '0;
            r_ptot  <= '0;
            r_clr   <= '0;
            r_sub   <= '0;
            for (int v = 0; v < MAX_CANDIDATES; v++) r_lock[v] <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_ncfg <= i_cfg_data;
            unique case (r_state)
                ST_IDLE: begin
                    r_i <= '0; r_j <= 5'd1; r_sub <= '0; r_ptot <= '0; r_clr <= '0;
                    if (accept && i_word.mode == MODE_RANK && !r_abort) begin
                        if ({1'b0, i_word.candidate} >= n_eff) begin
                            r_abort <= 1'b1;
                            r_pos   <= '0;
                        end else begin
                            if (r_pos >= n_eff) begin
                                r_ranks[0] <= i_word.candidate[CW-1:0];
                                r_pos <= (5'd1 >= n_eff) ? 5'd0 : 5'd1;
                            end else begin
                                r_ranks[r_pos[CW-1:0]] <= i_word.candidate[CW-1:0];
                                r_pos <= (r_pos + 5'd1 >= n_eff) ? 5'd0 : r_pos + 5'd1;
                            end
                        end
                    end
                end
                ST_REC_WR, ST_PAIR_CMP: begin
                    if (r_state == ST_PAIR_CMP && r_j + 5'd1 >= n_eff
                        && r_i + 5'd2 >= n_eff) begin
                        // last pair formed, first insertion pass starts at slot one
                        r_i <= 5'd1;
                        r_k <= PW'(1);
                    end else if (r_j + 5'd1 >= n_eff) begin
                        r_i <= r_i + 5'd1;
                        r_j <= r_i + 5'd2;
                    end else begin
                        r_j <= r_j + 5'd1;
                    end
                    if (r_state == ST_PAIR_CMP) begin
                        r_sub <= '0;
                        if (r_a != r_rd_data) begin
                            r_pw[r_ptot] <= (r_a > r_rd_data) ? r_i[CW-1:0] : r_j[CW-1:0];
                            r_pl[r_ptot] <= (r_a > r_rd_data) ? r_j[CW-1:0] : r_i[CW-1:0];
                            r_ptot <= r_ptot + 1'b1;
                        end
                    end
                end
                ST_PAIR_RD: begin
                    r_sub <= r_sub + 2'd1;
                    if (r_sub == 2'd1) r_a <= r_rd_data;
                    if (n_eff < 5'd2) r_k <= '0;
                end
                ST_SORT_RD: begin
                    // r_i: pass index, r_k: insertion slot being compared
                    if (r_sub == 2'd0) r_sub <= 2'd1;
                    else if (r_sub == 2'd1) begin
                        r_a <= r_rd_data;
                        r_sub <= 2'd2;
                    end else begin
                        r_sub <= 2'd2;
                    end
                    if ({1'b0, r_i} >= {1'b0, 5'(r_ptot)}) begin
                        r_k <= '0;
                        r_seen <= '0;
                    end
                end
                ST_SORT_CMP: begin
                    // r_a-r_rd_data is margin of pair at r_k; key held in r_m
                    if (r_k == PW'(r_i)) begin
                        r_m <= cur_m;
                        if (r_k != '0) begin
                            r_k <= r_k - 1'b1; r_sub <= '0;
                        end else begin
                            r_i <= r_i + 5'd1; r_k <= PW'(r_i + 5'd1); r_sub <= '0;
                        end
                    end else if (cur_m < r_m) begin
                        r_pw[r_k] <= r_pw[r_k + 1'b1];
                        r_pl[r_k] <= r_pl[r_k + 1'b1];
                        r_pw[r_k + 1'b1] <= r_pw[r_k];
                        r_pl[r_k + 1'b1] <= r_pl[r_k];
                        if (r_k != '0) r_k <= r_k - 1'b1;
                        else begin
                            r_i <= r_i + 5'd1; r_k <= PW'(r_i + 5'd1);
                        end
                        r_sub <= '0;
                    end else begin
                        r_i <= r_i + 5'd1; r_k <= PW'(r_i + 5'd1); r_sub <= '0;
                    end
                end
                ST_LOCK: begin
                    r_round <= '0;
                    // walk starts from the loser of the pair
                    r_seen  <= (r_k < r_ptot) ? (MAX_CANDIDATES'(1) << sl) : '0;
                    r_i     <= '0;
                    r_roots <= roots;
                end
                ST_REACH: begin
                    r_seen  <= grown;
                    r_round <= r_round + 5'd1;
                    if (r_round + 5'd1 >= n_eff) begin
                        if (!grown[sw]) r_lock[sw][sl] <= 1'b1;
                        r_k <= r_k + 1'b1;
                    end
                end
                ST_EMIT: r_i <= r_i + 5'd1;
                ST_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW + 1)'(DEPTH - 1)) begin
                        r_abort <= 1'b0;
                        r_pos   <= '0;
                        for (int v = 0; v < MAX_CANDIDATES; v++) r_lock[v] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
